FILE: sv/adcr_pkg.sv
// Package: shared types, constants and codes of the sampling ring unit.
package adcr_pkg;

    // Ring and burst geometry
    localparam int RING_BITS      = 12;
    localparam int PAGE_WORD_BITS = 10;
    localparam int BURST_LEN      = 100;
    localparam int REG_COUNT      = 8;
    localparam int REG_IDX_BITS   = $clog2(REG_COUNT);
    localparam int BURST_BITS     = $clog2(BURST_LEN + 1);
    localparam int SAMPLE_BITS    = 11;

    localparam logic [SAMPLE_BITS:0] SAW_WRAP       = 12'd1111;
    localparam logic [31:0]          UNMAPPED_VALUE = 32'h0BAD_A4EA;
    localparam logic [31:0]          PAGE_WORD_MASK = 32'((64'd1 << PAGE_WORD_BITS) - 64'd1);

    // Register word indexes
    localparam logic [5:0] IDX_DIV    = 6'd0;
    localparam logic [5:0] IDX_PAGE1  = 6'd1;
    localparam logic [5:0] IDX_READP  = 6'd5;
    localparam logic [5:0] IDX_WRITEP = 6'd6;
    localparam logic [5:0] IDX_CTRL   = 6'd7;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_TICK  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  word_index;
        logic [31:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [31:0]            read_data;
        logic                   dma_valid;
        logic [31:0]            dma_address;
        logic [SAMPLE_BITS-1:0] dma_sample;
        logic                   irq_line;
    } t_out_item;

endpackage

FILE: sv/adcr_core.sv
// Core: register file, ring pointers, burst sequencing and result logic.
module adcr_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  adcr_pkg::t_in_item i_item,
    output adcr_pkg::t_out_item o_result
);
    import adcr_pkg::*;

    logic [31:0]            r_regs [REG_COUNT];
    logic [31:0]            n_regs [REG_COUNT];
    logic [RING_BITS-1:0]   r_rp, n_rp, r_wp, n_wp;
    logic                   r_ovr, n_ovr, r_pend, n_pend, r_en, n_en, r_act, n_act;
    logic [31:0]            r_pc, n_pc;
    logic [BURST_BITS-1:0]  r_burst, n_burst;
    logic [SAMPLE_BITS-1:0] r_sample, n_sample;

    logic [BURST_BITS-1:0]   burst_cur;
    logic [31:0]             pc_inc;
    logic [RING_BITS-1:0]    wp_next;
    logic [RING_BITS-1:0]    wp_shift;
    logic [1:0]              page;
    logic [REG_IDX_BITS-1:0] page_idx;
    logic [SAMPLE_BITS:0]    sample_inc;
    logic                    mapped;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < REG_COUNT; k++) begin
                r_regs[k] <= '0;
            end
            r_rp     <= '0;
            r_wp     <= '0;
            r_ovr    <= 1'b0;
            r_pend   <= 1'b0;
            r_en     <= 1'b1;
            r_act    <= 1'b0;
            r_pc     <= '0;
            r_burst  <= '0;
            r_sample <= '0;
        end else if (i_fire) begin
            r_regs   <= n_regs;
            r_rp     <= n_rp;
            r_wp     <= n_wp;
            r_ovr    <= n_ovr;
            r_pend   <= n_pend;
            r_en     <= n_en;
            r_act    <= n_act;
            r_pc     <= n_pc;
            r_burst  <= n_burst;
            r_sample <= n_sample;
        end
    end

    // Next state and result for one request
    always_comb begin
        n_regs   = r_regs;
        n_rp     = r_rp;
        n_wp     = r_wp;
        n_ovr    = r_ovr;
        n_pend   = r_pend;
        n_en     = r_en;
        n_act    = r_act;
        n_pc     = r_pc;
        n_burst  = r_burst;
        n_sample = r_sample;
        o_result = '0;

        mapped     = (i_item.word_index < 6'(REG_COUNT));
        burst_cur  = r_burst;
        pc_inc     = r_pc + 32'd1;
        wp_next    = r_wp + RING_BITS'(1);
        wp_shift   = r_wp >> PAGE_WORD_BITS;
        page       = wp_shift[1:0];
        page_idx   = REG_IDX_BITS'(IDX_PAGE1) + REG_IDX_BITS'(page);
        sample_inc = {1'b0, r_sample} + 12'd1;

        case (i_item.kind)
            KIND_READ: begin
                if (i_item.word_index == IDX_READP) begin
                    o_result.read_data = {r_ovr, r_pend, 30'(r_rp)};
                end else if (i_item.word_index == IDX_WRITEP) begin
                    o_result.read_data = 32'(r_wp);
                end else if (mapped) begin
                    o_result.read_data = r_regs[i_item.word_index[REG_IDX_BITS-1:0]];
                end else begin
                    o_result.read_data = UNMAPPED_VALUE;
                end
            end
            KIND_WRITE: begin
                if (mapped) begin
                    n_regs[i_item.word_index[REG_IDX_BITS-1:0]] = i_item.write_data;
                    if (i_item.word_index == IDX_DIV) begin
                        n_rp    = '0;
                        n_wp    = '0;
                        n_ovr   = 1'b0;
                        n_pc    = '0;
                        n_burst = '0;
                        n_act   = (i_item.write_data != 32'd0);
                    end else if (i_item.word_index == IDX_READP) begin
                        n_rp = i_item.write_data[RING_BITS-1:0];
                    end else if (i_item.word_index == IDX_CTRL) begin
                        n_en = i_item.write_data[0];
                    end
                end
            end
            KIND_TICK: begin
                if (r_act) begin
                    // period count, then start a burst when the divider is reached
                    if (r_burst == '0) begin
                        if (pc_inc >= r_regs[REG_IDX_BITS'(IDX_DIV)]) begin
                            n_pc      = '0;
                            burst_cur = BURST_BITS'(BURST_LEN);
                        end else begin
                            n_pc = pc_inc;
                        end
                    end
                    n_burst = burst_cur;
                    // one sample of the burst, or overrun
                    if (burst_cur != '0) begin
                        if (wp_next == r_rp) begin
                            n_ovr   = 1'b1;
                            n_act   = 1'b0;
                            n_burst = '0;
                            n_pend  = 1'b1;
                        end else begin
                            o_result.dma_valid   = 1'b1;
                            o_result.dma_address = r_regs[page_idx] +
                                                   ((32'(r_wp) & PAGE_WORD_MASK) << 2);
                            o_result.dma_sample  = r_sample;
                            n_wp     = wp_next;
                            n_sample = (sample_inc >= SAW_WRAP) ? '0
                                                                : sample_inc[SAMPLE_BITS-1:0];
                            n_burst  = burst_cur - BURST_BITS'(1);
                            if (n_burst == '0) begin
                                n_pend = 1'b1;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        o_result.irq_line = n_pend & n_en;
    end

endmodule

FILE: sv/dma_sampling_adc_ring.sv
// Top level: request register, sampling core and result register.
//
// Sampling unit that writes a sawtooth into a ring buffer over four host
// pages. Each request on the input channel is a bus read, a bus write or
// one time tick; each request gives exactly one result on the output
// channel (read data, an optional DMA sample write and the irq level).
// Both channels use valid/ready.
// An accepted request lands in the request register, and its result is
// captured in the result register when that register is free.
// Throughput: one request per cycle while the receiver takes results;
// the state update is a single pass of a 32-bit period compare, pointer
// increment and register file reads.
// Reset (synchronous, active low) clears registers, pointers, flags and the
// burst, and sets the interrupt enable.
// When the receiver stalls, the result register holds, the request
// register fills, and then o_in_ready drops until the result is taken.
module dma_sampling_adc_ring (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  adcr_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output adcr_pkg::t_out_item o_out_item
);
    import adcr_pkg::*;

    logic      r_req_valid;
    t_in_item  r_req;
    logic      r_res_valid;
    t_out_item r_res;
    logic      advance;
    t_out_item result;

    // Request moves to the result register when that register is free
    assign advance    = r_req_valid && (!r_res_valid || i_out_ready);
    assign o_in_ready = !r_req_valid || advance;

    // Request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_req_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req <= i_in_item;
        end
    end

    adcr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_req),
        .o_result (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (advance) begin
            r_res_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= result;
        end
    end

    assign o_out_valid = r_res_valid;
    assign o_out_item  = r_res;

endmodule
